@@ rtl/dsa_pkg.sv @@
`default_nettype none

package dsa_pkg;

    localparam int ADC_W     = 12;
    localparam int GAIN_W    = 16;
    localparam int CONC_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // full-precision scaled value: diff * gain, fraction dropped
    localparam int SCALED_W = ADC_W + GAIN_W - FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_DUST = 3'd0,
        CFG_GAIN      = 3'd1,
        CFG_CLAMP_MIN = 3'd2,
        CFG_CLAMP_MAX = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [ADC_W-1:0]  zero_dust_code;
        logic [GAIN_W-1:0] gain_q8;
        logic [CONC_W-1:0] clamp_min;
        logic [CONC_W-1:0] clamp_max;
    } cfg_regs_t;

    localparam logic [ADC_W-1:0]  ZERO_DUST_RESET = 12'd0;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd256;
    localparam logic [CONC_W-1:0] CLAMP_MIN_RESET = 16'd0;
    localparam logic [CONC_W-1:0] CLAMP_MAX_RESET = 16'hFFFF;

endpackage

`default_nettype wire

@@ rtl/dsa_scale.sv @@
`default_nettype none

module dsa_scale (
    input  wire logic [dsa_pkg::ADC_W-1:0]  code,
    input  wire dsa_pkg::cfg_regs_t         cfg,
    output logic      [dsa_pkg::CONC_W-1:0] conc
);

    localparam int PROD_W = dsa_pkg::ADC_W + dsa_pkg::GAIN_W;

    logic [dsa_pkg::ADC_W-1:0]    diff;
    logic [PROD_W-1:0]            prod;
    logic [dsa_pkg::SCALED_W-1:0] scaled;
    logic [dsa_pkg::SCALED_W-1:0] max_ext;
    logic [dsa_pkg::SCALED_W-1:0] min_ext;

    // codes at or below the zero-dust level scale to zero
    assign diff = (code > cfg.zero_dust_code) ? (code - cfg.zero_dust_code) : '0;
    assign prod = {{dsa_pkg::GAIN_W{1'b0}}, diff} * {{dsa_pkg::ADC_W{1'b0}}, cfg.gain_q8};
    assign scaled = prod[PROD_W-1:dsa_pkg::FRAC_BITS];

    assign max_ext = {{(dsa_pkg::SCALED_W-dsa_pkg::CONC_W){1'b0}}, cfg.clamp_max};
    assign min_ext = {{(dsa_pkg::SCALED_W-dsa_pkg::CONC_W){1'b0}}, cfg.clamp_min};

    // max check wins when min > max
    always_comb begin
        if (scaled > max_ext) begin
            conc = cfg.clamp_max;
        end else if (scaled < min_ext) begin
            conc = cfg.clamp_min;
        end else begin
            conc = scaled[dsa_pkg::CONC_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dsa_window.sv @@
`default_nettype none

module dsa_window #(
    parameter int WINDOW_LENGTH = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        shift_en,
    input  wire logic [dsa_pkg::CONC_W-1:0]  conc_in,
    output logic      [dsa_pkg::CONC_W-1:0]  conc_out,
    output logic      [dsa_pkg::CONC_W-1:0]  mean_out
);

    localparam int LOG_W = $clog2(WINDOW_LENGTH);
    localparam int SUM_W = dsa_pkg::CONC_W + LOG_W;

    logic [dsa_pkg::CONC_W-1:0] line_reg [WINDOW_LENGTH];
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic [dsa_pkg::CONC_W-1:0] conc_reg;

    // oldest sample drops out as the new one enters
    assign sum_next = sum_reg
                    - {{LOG_W{1'b0}}, line_reg[WINDOW_LENGTH-1]}
                    + {{LOG_W{1'b0}}, conc_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                line_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (shift_en) begin
            line_reg[0] <= conc_in;
            for (int i = 1; i < WINDOW_LENGTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            conc_reg <= conc_in;
        end
    end

    assign conc_out = conc_reg;

    generate
        if ((1 << LOG_W) == WINDOW_LENGTH) begin : g_pow2
            assign mean_out = sum_reg[SUM_W-1:LOG_W];
        end else begin : g_recip
            // floor(sum / W) as (sum * ceil(2^SHIFT / W)) >> SHIFT, exact for SUM_W-bit sums
            localparam int SHIFT = SUM_W + LOG_W;
            localparam int PROD_W = 2 * SUM_W + 1;
            localparam logic [63:0] RECIP_FULL =
                ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
            localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

            logic [PROD_W-1:0] prod;

            assign prod = {{(SUM_W+1){1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP};
            assign mean_out = prod[SHIFT +: dsa_pkg::CONC_W];
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/dust_sensor_scale_and_average.sv @@
// Dust sensor scaling and moving average.
// Input channel (s_valid/s_ready, s_adc_sample) takes one 12-bit ADC code per
// transaction. Each code is offset by the zero-dust code, scaled by the Q8.8
// gain and clamped (max first, then min). The result channel (m_valid/m_ready)
// returns that concentration and the truncated mean of the last WINDOW_LENGTH
// concentrations, this one included.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 zero-dust code, 1 gain, 2 clamp min, 3 clamp max, others ignored.
// Write config only while no transaction is in flight.
// Three register stages: scale, window sum update, mean. One transaction per
// cycle is sustained while m_ready stays high; the scaling multiply and the
// running-sum update each take one stage. Reset clears the window (empty slots
// count as zero), the running sum and the pipeline, and loads the register
// defaults. When m_ready is low the pipeline keeps filling its empty stages,
// then s_ready drops.
`default_nettype none

module dust_sensor_scale_and_average #(
    parameter int WINDOW_LENGTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dsa_pkg::ADC_W-1:0]       s_adc_sample,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [dsa_pkg::CONC_W-1:0]      m_concentration,
    output logic      [dsa_pkg::CONC_W-1:0]      m_window_mean,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dsa_pkg::cfg_regs_t cfg_reg;

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       m_valid_reg;
    logic [dsa_pkg::CONC_W-1:0] conc1_reg;
    logic [dsa_pkg::CONC_W-1:0] conc_scaled;
    logic [dsa_pkg::CONC_W-1:0] conc2;
    logic [dsa_pkg::CONC_W-1:0] mean2;
    logic [dsa_pkg::CONC_W-1:0] m_concentration_reg;
    logic [dsa_pkg::CONC_W-1:0] m_window_mean_reg;

    logic out_ready;
    logic ready2;
    logic adv1;
    logic adv2;
    logic s_accept;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_dust_code <= dsa_pkg::ZERO_DUST_RESET;
            cfg_reg.gain_q8        <= dsa_pkg::GAIN_RESET;
            cfg_reg.clamp_min      <= dsa_pkg::CLAMP_MIN_RESET;
            cfg_reg.clamp_max      <= dsa_pkg::CLAMP_MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (dsa_pkg::cfg_reg_t'(cfg_index))
                dsa_pkg::CFG_ZERO_DUST: begin
                    cfg_reg.zero_dust_code <= cfg_data[dsa_pkg::ADC_W-1:0];
                end
                dsa_pkg::CFG_GAIN: begin
                    cfg_reg.gain_q8 <= cfg_data[dsa_pkg::GAIN_W-1:0];
                end
                dsa_pkg::CFG_CLAMP_MIN: begin
                    cfg_reg.clamp_min <= cfg_data[dsa_pkg::CONC_W-1:0];
                end
                dsa_pkg::CFG_CLAMP_MAX: begin
                    cfg_reg.clamp_max <= cfg_data[dsa_pkg::CONC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control: a stage loads when it is empty or drains
    assign out_ready = !m_valid_reg || m_ready;
    assign ready2    = !v2_reg || out_ready;
    assign s_ready   = !v1_reg || ready2;
    assign adv2      = v2_reg && out_ready;
    assign adv1      = v1_reg && ready2;
    assign s_accept  = s_valid && s_ready;

    dsa_scale u_scale (
        .code (s_adc_sample),
        .cfg  (cfg_reg),
        .conc (conc_scaled)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            conc1_reg <= conc_scaled;
        end
    end

    dsa_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (adv1),
        .conc_in  (conc1_reg),
        .conc_out (conc2),
        .mean_out (mean2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (out_ready) begin
                m_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_concentration_reg <= conc2;
            m_window_mean_reg   <= mean2;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_concentration = m_concentration_reg;
    assign m_window_mean   = m_window_mean_reg;

    // an empty output stage never back-pressures the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty output stage");

    // an accepted transaction always lands in the scale stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> v1_reg)
        else $error("accepted transaction lost at scale stage");

    // a blocked window stage keeps its item and its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !out_ready) |=> (v2_reg && $stable(conc2) && $stable(mean2)))
        else $error("window stage changed while stalled");

endmodule

`default_nettype wire
